### rtl/dbts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbts_pkg
// Shared widths, codes, operand types and rounding/saturation helpers for the
// dead-blending transition smoother.
// ----------------------------------------------------------------------------
package dbts_pkg;

  // Value formats
  localparam int VAL_W   = 32;  // Q16.16 signed
  localparam int STEP_W  = 17;  // tick step, Q1.16 unsigned
  localparam int BLEND_W = 19;  // blend time, Q3.16 unsigned
  localparam int FACT_W  = 17;  // decay factor, Q0.16 unsigned
  localparam int ALPHA_W = 17;  // alpha / ratio, Q0.16, 0..65536
  localparam int ELAP_W  = BLEND_W + 1;  // elapsed stays below 2^19 + 2^17
  localparam int QUO_W   = 16;  // ratio bits from the divider

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = BLEND_W;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_TIME   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_ENABLE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR = 2'd3;

  localparam logic [STEP_W-1:0]  TICK_STEP_RST    = 17'd1092;
  localparam logic [BLEND_W-1:0] BLEND_TIME_RST   = 19'd32768;
  localparam logic [FACT_W-1:0]  DECAY_FACTOR_RST = 17'd62576;

  // Operation codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Shared multiplier
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 19;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int SAT_W   = MUL_P_W + 1;

  typedef logic signed [MUL_A_W-1:0] mul_a_t;
  typedef logic signed [MUL_B_W-1:0] mul_b_t;
  typedef logic signed [MUL_P_W-1:0] mul_p_t;
  typedef logic signed [SAT_W-1:0]   sat_in_t;

  // Smoothstep constants (Q0.16)
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;
  localparam logic [17:0]        THREE_ONE = 18'd196608;  // 3.0
  localparam int                 ALPHA_LSB = 32;
  localparam logic [MUL_P_W-1:0] HALF_32   = MUL_P_W'(64'h8000_0000);

  // Divider
  localparam int DIV_STEPS = QUO_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // floor((p + 2^15) / 2^16)
  function automatic mul_p_t round16(input mul_p_t p);
    mul_p_t t;
    t = p + MUL_P_W'(32768);
    return t >>> 16;
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic signed [VAL_W-1:0] sat32(input sat_in_t v);
    logic fits;
    fits = (v[SAT_W-1:VAL_W-1] == '0) || (v[SAT_W-1:VAL_W-1] == '1);
    if (fits) begin
      return v[VAL_W-1:0];
    end else if (v[SAT_W-1]) begin
      return {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      return {1'b0, {(VAL_W-1){1'b1}}};
    end
  endfunction

endpackage

### rtl/dbts_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbts_mul
// Shared signed multiplier with a registered product; every product of the
// blend (decay, extrapolation, smoothstep, interpolation) goes through it.
// ----------------------------------------------------------------------------
module dbts_mul (
  input  logic              clk,
  input  logic              en,
  input  dbts_pkg::mul_a_t  a,
  input  dbts_pkg::mul_b_t  b,
  output dbts_pkg::mul_p_t  prod
);

  // Product register
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= dbts_pkg::mul_p_t'(a) * dbts_pkg::mul_p_t'(b);
    end
  end

endmodule

### rtl/dbts_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbts_div
// Restoring divider, one quotient bit per cycle. Returns
// floor(dividend * 2^16 / divisor) for dividend < divisor.
// ----------------------------------------------------------------------------
module dbts_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [dbts_pkg::BLEND_W-1:0]       dividend,
  input  logic [dbts_pkg::BLEND_W-1:0]       divisor,
  output logic                               busy,
  output logic [dbts_pkg::QUO_W-1:0]         quotient
);

  logic [dbts_pkg::DIV_CNT_W-1:0] count;
  logic [dbts_pkg::BLEND_W-1:0]   rem;
  logic [dbts_pkg::BLEND_W-1:0]   rem_next;
  logic [dbts_pkg::BLEND_W:0]     shifted;
  logic                           take;

  // One restoring step
  always_comb begin
    shifted  = {rem, 1'b0};
    take     = shifted >= {1'b0, divisor};
    rem_next = take ? dbts_pkg::BLEND_W'(shifted - {1'b0, divisor})
                    : shifted[dbts_pkg::BLEND_W-1:0];
  end

  assign busy = (count != '0);

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= dbts_pkg::DIV_CNT_W'(dbts_pkg::DIV_STEPS);
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

  // Remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      quotient <= '0;
    end else if (busy) begin
      rem      <= rem_next;
      quotient <= {quotient[dbts_pkg::QUO_W-2:0], take};
    end
  end

endmodule

### rtl/dead_blending_transition_smoother.sv
`timescale 1ns / 1ps
// A transition is absorbed without leaving idle; a pass-through tick goes
// from idle through S_OUT to the output register; a blended tick also runs
// the extrapolation, the 16-step serial ratio divider (skipped once the
// blend time is covered) and the shared multiplier; decay adds a pass.
// One item at a time: in_stall holds off transfers until back in idle.
// Reset (sync, active high) restores register defaults and ends any blend.
// ----------------------------------------------------------------------------
// dead_blending_transition_smoother
// Inertialization by extrapolation: holds a source position/velocity,
// extrapolates it each tick and blends it toward the target with a
// smoothstep weight until the blend time runs out.
// ----------------------------------------------------------------------------
module dead_blending_transition_smoother (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_write,
  input  logic [dbts_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dbts_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 operation,
  input  logic signed [dbts_pkg::VAL_W-1:0]    position,
  input  logic signed [dbts_pkg::VAL_W-1:0]    velocity,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [dbts_pkg::VAL_W-1:0]    out_position,
  output logic signed [dbts_pkg::VAL_W-1:0]    out_velocity,
  output logic                                 blending
);

  // Sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECAY    = 4'd1;
  localparam logic [3:0] S_DECAY_WB = 4'd2;
  localparam logic [3:0] S_EXT      = 4'd3;
  localparam logic [3:0] S_EXT_WB   = 4'd4;
  localparam logic [3:0] S_DIV      = 4'd5;
  localparam logic [3:0] S_RR       = 4'd6;
  localparam logic [3:0] S_K        = 4'd7;
  localparam logic [3:0] S_ALPHA    = 4'd8;
  localparam logic [3:0] S_LX       = 4'd9;
  localparam logic [3:0] S_LX_WB    = 4'd10;
  localparam logic [3:0] S_LV_WB    = 4'd11;
  localparam logic [3:0] S_OUT      = 4'd12;

  logic [3:0] state;

  // Configuration registers
  logic [dbts_pkg::STEP_W-1:0]  tick_step;
  logic [dbts_pkg::BLEND_W-1:0] blend_time;
  logic                         decay_enable;
  logic [dbts_pkg::FACT_W-1:0]  decay_factor;

  // Blend state
  logic signed [dbts_pkg::VAL_W-1:0] held_position;
  logic signed [dbts_pkg::VAL_W-1:0] held_velocity;
  logic [dbts_pkg::ELAP_W-1:0]       elapsed;
  logic                              blend_active;

  // Working registers
  logic signed [dbts_pkg::VAL_W-1:0] tgt_pos;
  logic signed [dbts_pkg::VAL_W-1:0] tgt_vel;
  logic [dbts_pkg::ALPHA_W-1:0]      ratio;
  logic [dbts_pkg::ALPHA_W-1:0]      alpha;
  logic signed [dbts_pkg::VAL_W-1:0] res_pos;
  logic signed [dbts_pkg::VAL_W-1:0] res_vel;
  logic                              res_blend;

  // Shared units
  dbts_pkg::mul_a_t mul_a;
  dbts_pkg::mul_b_t mul_b;
  dbts_pkg::mul_p_t prod;
  logic             mul_en;
  logic             div_start;
  logic             div_busy;
  logic [dbts_pkg::QUO_W-1:0] div_q;

  logic signed [dbts_pkg::VAL_W:0] dx;
  logic signed [dbts_pkg::VAL_W:0] dv;
  logic [17:0]                     k3;
  dbts_pkg::mul_p_t                prod_rnd;
  logic [dbts_pkg::MUL_P_W-1:0]    alpha_sum;
  logic                            in_xfer;
  logic                            out_free;
  logic                            in_blend;

  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign in_blend  = blend_active && (elapsed < {1'b0, blend_time});
  assign div_start = (state == S_EXT_WB) && (elapsed < {1'b0, blend_time});

  // Interpolation spans and smoothstep factor
  assign dx        = (dbts_pkg::VAL_W+1)'(tgt_pos) - (dbts_pkg::VAL_W+1)'(held_position);
  assign dv        = (dbts_pkg::VAL_W+1)'(tgt_vel) - (dbts_pkg::VAL_W+1)'(held_velocity);
  assign k3        = dbts_pkg::THREE_ONE - {ratio, 1'b0};
  assign prod_rnd  = dbts_pkg::round16(prod);
  assign alpha_sum = $unsigned(prod) + dbts_pkg::HALF_32;

  // Multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    unique case (state)
      S_DECAY: begin
        mul_a = dbts_pkg::MUL_A_W'(held_velocity);
        mul_b = {2'b00, decay_factor};
      end
      S_EXT: begin
        mul_a = dbts_pkg::MUL_A_W'(held_velocity);
        mul_b = {2'b00, tick_step};
      end
      S_RR: begin
        mul_a = {{(dbts_pkg::MUL_A_W-dbts_pkg::ALPHA_W){1'b0}}, ratio};
        mul_b = {2'b00, ratio};
      end
      S_K: begin
        mul_a = {1'b0, prod[32:0]};
        mul_b = {1'b0, k3};
      end
      S_LX: begin
        mul_a = dbts_pkg::MUL_A_W'(dx);
        mul_b = {2'b00, alpha};
      end
      S_LX_WB: begin
        mul_a = dbts_pkg::MUL_A_W'(dv);
        mul_b = {2'b00, alpha};
      end
      default: begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
      end
    endcase
  end

  dbts_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  dbts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (elapsed[dbts_pkg::BLEND_W-1:0]),
    .divisor  (blend_time),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_step    <= dbts_pkg::TICK_STEP_RST;
      blend_time   <= dbts_pkg::BLEND_TIME_RST;
      decay_enable <= 1'b0;
      decay_factor <= dbts_pkg::DECAY_FACTOR_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dbts_pkg::CFG_TICK_STEP:    tick_step    <= cfg_data[dbts_pkg::STEP_W-1:0];
        dbts_pkg::CFG_BLEND_TIME:   blend_time   <= cfg_data;
        dbts_pkg::CFG_DECAY_ENABLE: decay_enable <= cfg_data[0];
        dbts_pkg::CFG_DECAY_FACTOR: decay_factor <= cfg_data[dbts_pkg::FACT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and blend state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      blend_active  <= 1'b0;
      held_position <= '0;
      held_velocity <= '0;
      elapsed       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (operation == dbts_pkg::OP_START) begin
              held_position <= position;
              held_velocity <= velocity;
              elapsed       <= '0;
              blend_active  <= 1'b1;
            end else if (in_blend) begin
              state <= decay_enable ? S_DECAY : S_EXT;
            end else begin
              blend_active <= 1'b0;
              state        <= S_OUT;
            end
          end
        end
        S_DECAY:    state <= S_DECAY_WB;
        S_DECAY_WB: begin
          held_velocity <= dbts_pkg::sat32(dbts_pkg::SAT_W'(prod_rnd));
          state         <= S_EXT;
        end
        S_EXT: begin
          elapsed <= elapsed + dbts_pkg::ELAP_W'(tick_step);
          state   <= S_EXT_WB;
        end
        S_EXT_WB: begin
          held_position <= dbts_pkg::sat32(dbts_pkg::SAT_W'(held_position)
                                           + dbts_pkg::SAT_W'(prod_rnd));
          state <= div_start ? S_DIV : S_RR;
        end
        S_DIV:      if (!div_busy) state <= S_RR;
        S_RR:       state <= S_K;
        S_K:        state <= S_ALPHA;
        S_ALPHA:    state <= S_LX;
        S_LX:       state <= S_LX_WB;
        S_LX_WB:    state <= S_LV_WB;
        S_LV_WB:    state <= S_OUT;
        S_OUT:      if (out_free) state <= S_IDLE;
        default:    state <= S_IDLE;
      endcase
    end
  end

  // Working datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_xfer) begin
      tgt_pos   <= position;
      tgt_vel   <= velocity;
      res_pos   <= position;
      res_vel   <= velocity;
      res_blend <= 1'b0;
    end
    // ratio: capped at one once the blend time is covered
    if (state == S_EXT_WB && !div_start) begin
      ratio <= dbts_pkg::ALPHA_ONE;
    end else if (state == S_DIV && !div_busy) begin
      ratio <= {1'b0, div_q};
    end
    if (state == S_ALPHA) begin
      alpha <= alpha_sum[dbts_pkg::ALPHA_LSB +: dbts_pkg::ALPHA_W];
    end
    if (state == S_LX_WB) begin
      res_pos <= dbts_pkg::sat32(dbts_pkg::SAT_W'(held_position)
                                 + dbts_pkg::SAT_W'(prod_rnd));
    end
    if (state == S_LV_WB) begin
      res_vel   <= dbts_pkg::sat32(dbts_pkg::SAT_W'(held_velocity)
                                   + dbts_pkg::SAT_W'(prod_rnd));
      res_blend <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_position <= res_pos;
      out_velocity <= res_vel;
      blending     <= res_blend;
    end
  end

endmodule
